@@ sv/qph_pkg.sv @@
// ----------------------------------------------------------------------------
// qph_pkg: shared types and constants for the quadratic probe hash insert
// Holds payload types, the sequencer state type and the slot store command.
// ----------------------------------------------------------------------------
package qph_pkg;

    // Field widths fixed by the block's interface.
    localparam int KEY_W   = 31;
    localparam int SIZE_W  = 11;
    localparam int SLOT_W  = 10;

    // Remainder unit takes one key bit per cycle.
    localparam int DIV_STEPS = KEY_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Probe marks carry an item epoch; zero means never probed.
    localparam int EPOCH_W = 16;

    // Table size after reset.
    localparam logic [SIZE_W-1:0] TABLE_SIZE_RESET = 11'd1021;

    typedef logic [KEY_W-1:0]   key_t;
    typedef logic [SIZE_W-1:0]  size_cfg_t;
    typedef logic [SLOT_W-1:0]  slot_t;
    typedef logic [EPOCH_W-1:0] epoch_t;

    localparam epoch_t EPOCH_FIRST = epoch_t'(1);
    localparam epoch_t EPOCH_NONE  = '0;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_READ,
        ST_CHECK
    } state_t;

    // Write command from the sequencer to the slot store.
    typedef struct packed {
        logic occ_we;
        logic occ_data;
        logic tag_we;
    } store_cmd_t;

endpackage

@@ sv/qph_ifaces.sv @@
// ----------------------------------------------------------------------------
// qph_ifaces: valid/ready channels of the quadratic probe hash insert
// One channel carries keys in, the other carries insert results out.
// ----------------------------------------------------------------------------
interface qph_key_if;
    import qph_pkg::*;

    logic valid;
    logic ready;
    key_t key;

    modport source (output valid, output key, input ready);
    modport sink   (input valid, input key, output ready);
endinterface

interface qph_res_if;
    import qph_pkg::*;

    logic  valid;
    logic  ready;
    logic  inserted;
    slot_t slot_index;

    modport source (output valid, output inserted, output slot_index, input ready);
    modport sink   (input valid, input inserted, input slot_index, output ready);
endinterface

@@ sv/qph_mod_unit.sv @@
// ----------------------------------------------------------------------------
// qph_mod_unit: bit-serial remainder unit
// Computes key mod size by restoring division, one key bit per cycle.
// ----------------------------------------------------------------------------
module qph_mod_unit #(
    parameter int SW = 11
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  qph_pkg::key_t     dividend,
    input  logic [SW-1:0]     divisor,
    output logic              done,
    output logic [SW-1:0]     remainder
);
    import qph_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    key_t                 shift_reg, shift_next;
    logic [SW-1:0]        div_reg, div_next;
    logic [SW-1:0]        rem_reg, rem_next;
    logic [SW:0]          trial;
    logic                 last_step;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        div_reg   <= div_next;
        rem_reg   <= rem_next;
    end

    // One restoring step: bring in the next key bit, subtract if it fits.
    always_comb
    begin
        trial      = {rem_reg, shift_reg[KEY_W-1]};
        last_step  = (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        div_next   = div_reg;
        rem_next   = rem_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            cnt_next   = '0;
            shift_next = dividend;
            div_next   = divisor;
            rem_next   = '0;
        end
        else if (busy_reg)
        begin
            shift_next = {shift_reg[KEY_W-2:0], 1'b0};
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = SW'(trial - {1'b0, div_reg});
            end
            else
            begin
                rem_next = SW'(trial);
            end
            cnt_next = cnt_reg + DIV_CNT_W'(1);
            if (last_step)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

@@ sv/qph_slot_store.sv @@
// ----------------------------------------------------------------------------
// qph_slot_store: occupancy and probe mark memories
// One write and one registered read per cycle on each memory.
// ----------------------------------------------------------------------------
module qph_slot_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                 clk,
    input  qph_pkg::store_cmd_t  cmd,
    input  logic [AW-1:0]        wr_addr,
    input  qph_pkg::epoch_t      tag_wdata,
    input  logic [AW-1:0]        rd_addr,
    output logic                 rd_occ,
    output qph_pkg::epoch_t      rd_tag
);
    import qph_pkg::*;

    logic   occ_mem [DEPTH];
    epoch_t tag_mem [DEPTH];
    logic   rd_occ_reg;
    epoch_t rd_tag_reg;

    // Occupancy memory.
    always_ff @(posedge clk)
    begin
        if (cmd.occ_we)
        begin
            occ_mem[wr_addr] <= cmd.occ_data;
        end
        rd_occ_reg <= occ_mem[rd_addr];
    end

    // Probe mark memory.
    always_ff @(posedge clk)
    begin
        if (cmd.tag_we)
        begin
            tag_mem[wr_addr] <= tag_wdata;
        end
        rd_tag_reg <= tag_mem[rd_addr];
    end

    assign rd_occ = rd_occ_reg;
    assign rd_tag = rd_tag_reg;

endmodule

@@ sv/quadratic_probe_hash_insert.sv @@
// ----------------------------------------------------------------------------
// Steps: the word is accepted, the bit-serial remainder unit runs, the remainder
// is taken, then each probe reads a slot (ST_READ) and checks it (ST_CHECK).
// Throughput: one word at a time; the next word is accepted the cycle after
// the result is loaded, unless a probe mark clearing pass follows it.
// Reset: a clearing pass over all MAX_SLOTS slots empties the table; after every
// 65535 words a clearing pass clears the probe marks only.
// ----------------------------------------------------------------------------
// quadratic_probe_hash_insert: open addressing insert with quadratic probing
// Finds key mod size, then probes home + i*i until a free or repeated slot.
// ----------------------------------------------------------------------------
module quadratic_probe_hash_insert #(
    parameter int MAX_SLOTS = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  qph_pkg::size_cfg_t  cfg_wdata,
    qph_key_if.sink             req,
    qph_res_if.source           rsp
);
    import qph_pkg::*;

    localparam int AW = $clog2(MAX_SLOTS);
    localparam int SW = $clog2(MAX_SLOTS + 1);
    localparam int CW = SW + 1;

    state_t        state_reg, state_next;
    size_cfg_t     table_size_reg;
    logic [SW-1:0] size_reg, size_next;
    logic [SW-1:0] size_eff;
    logic [AW-1:0] pos_reg, pos_next;
    logic [AW-1:0] incr_reg, incr_next;
    epoch_t        epoch_reg, epoch_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;
    logic          clr_occ_reg, clr_occ_next;
    logic          out_valid_reg, out_valid_next;
    logic          out_inserted_reg, out_inserted_next;
    slot_t         out_slot_reg, out_slot_next;

    logic          mod_start;
    logic          mod_done;
    logic [SW-1:0] mod_rem;
    store_cmd_t    cmd;
    logic [AW-1:0] wr_addr;
    logic          rd_occ;
    epoch_t        rd_tag;
    logic          out_free;
    logic [CW-1:0] pos_sum;
    logic [CW-1:0] incr_sum;
    logic [CW-1:0] incr_once;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg <= TABLE_SIZE_RESET;
        end
        else if (cfg_we)
        begin
            table_size_reg <= cfg_wdata;
        end
    end

    // Size in use: zero counts as one, large values saturate to the store.
    always_comb
    begin
        if (table_size_reg == '0)
        begin
            size_eff = SW'(1);
        end
        else if (32'(table_size_reg) > MAX_SLOTS)
        begin
            size_eff = SW'(MAX_SLOTS);
        end
        else
        begin
            size_eff = SW'(table_size_reg);
        end
    end

    // Remainder unit.
    qph_mod_unit #(
        .SW (SW)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (req.key),
        .divisor   (size_eff),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    // Occupancy and probe marks.
    qph_slot_store #(
        .DEPTH (MAX_SLOTS),
        .AW    (AW)
    ) u_store (
        .clk       (clk),
        .cmd       (cmd),
        .wr_addr   (wr_addr),
        .tag_wdata ((state_reg == ST_CLEAR) ? EPOCH_NONE : epoch_reg),
        .rd_addr   (pos_reg),
        .rd_occ    (rd_occ),
        .rd_tag    (rd_tag)
    );

    // Next probe position: the step is 2*i+1 and grows by 2, both kept below size.
    always_comb
    begin
        pos_sum = CW'(pos_reg) + CW'(incr_reg);
        if (pos_sum >= CW'(size_reg))
        begin
            pos_sum = pos_sum - CW'(size_reg);
        end
        incr_sum = CW'(incr_reg) + CW'(2);
        if (incr_sum >= CW'(size_reg))
        begin
            incr_once = incr_sum - CW'(size_reg);
        end
        else
        begin
            incr_once = incr_sum;
        end
        if (incr_once >= CW'(size_reg))
        begin
            incr_once = incr_once - CW'(size_reg);
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            epoch_reg     <= EPOCH_FIRST;
            clr_addr_reg  <= '0;
            clr_occ_reg   <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            epoch_reg     <= epoch_next;
            clr_addr_reg  <= clr_addr_next;
            clr_occ_reg   <= clr_occ_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        size_reg         <= size_next;
        pos_reg          <= pos_next;
        incr_reg         <= incr_next;
        out_inserted_reg <= out_inserted_next;
        out_slot_reg     <= out_slot_next;
    end

    assign out_free = !out_valid_reg || rsp.ready;
    assign wr_addr  = (state_reg == ST_CLEAR) ? clr_addr_reg : pos_reg;

    // Sequencer: next state and outputs.
    always_comb
    begin
        state_next        = state_reg;
        size_next         = size_reg;
        pos_next          = pos_reg;
        incr_next         = incr_reg;
        epoch_next        = epoch_reg;
        clr_addr_next     = clr_addr_reg;
        clr_occ_next      = clr_occ_reg;
        out_inserted_next = out_inserted_reg;
        out_slot_next     = out_slot_reg;
        out_valid_next    = out_valid_reg && !rsp.ready;
        cmd               = '0;
        mod_start         = 1'b0;
        req.ready         = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.occ_we   = clr_occ_reg;
                cmd.occ_data = 1'b0;
                cmd.tag_we   = 1'b1;
                if (clr_addr_reg == AW'(MAX_SLOTS - 1))
                begin
                    clr_addr_next = '0;
                    clr_occ_next  = 1'b0;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + AW'(1);
                end
            end
            ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    mod_start  = 1'b1;
                    size_next  = size_eff;
                    incr_next  = (size_eff == SW'(1)) ? '0 : AW'(1);
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (mod_done)
                begin
                    pos_next   = AW'(mod_rem);
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (rd_tag == epoch_reg || !rd_occ)
                begin
                    // Final probe: a free slot, or a slot seen before.
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        if (rd_tag == epoch_reg)
                        begin
                            out_inserted_next = 1'b0;
                            out_slot_next     = '0;
                        end
                        else
                        begin
                            cmd.occ_we        = 1'b1;
                            cmd.occ_data      = 1'b1;
                            out_inserted_next = 1'b1;
                            out_slot_next     = SLOT_W'(pos_reg);
                        end
                        if (epoch_reg == '1)
                        begin
                            epoch_next = EPOCH_FIRST;
                            state_next = ST_CLEAR;
                        end
                        else
                        begin
                            epoch_next = epoch_reg + EPOCH_FIRST;
                            state_next = ST_IDLE;
                        end
                    end
                end
                else
                begin
                    // Occupied: mark it probed and move on.
                    cmd.tag_we = 1'b1;
                    pos_next   = AW'(pos_sum);
                    incr_next  = AW'(incr_once);
                    state_next = ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.inserted   = out_inserted_reg;
    assign rsp.slot_index = out_slot_reg;

endmodule
